// File: hdl/lzwd_pkg.sv
// Shared types and constants for the LZ window decompressor.
package lzwd_pkg;

    localparam int CNT_W = 27;
    localparam int LEN_W = 9;

    localparam logic [5:0]       MASK_BITS  = 6'd32;
    localparam logic [LEN_W-1:0] SHORT_BIAS = 9'd2;
    localparam logic [LEN_W-1:0] LONG_BIAS  = 9'd18;

    typedef enum logic [1:0] {
        KIND_MASK = 2'd0,
        KIND_LINK = 2'd1,
        KIND_BYTE = 2'd2,
        KIND_DONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FAR     = 2'd1,
        STAT_OVERRUN = 2'd2,
        STAT_KIND    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECODE = 3'b010,
        ST_COPY   = 3'b100
    } state_t;

    typedef struct packed {
        logic [63:0]      word;
        logic [3:0]       count;
        logic             last;
        kind_t            need;
        status_t          status;
        logic [CNT_W-1:0] total;
    } result_t;

endpackage

// File: hdl/lz_window_decompressor.sv
// Top level of the LZ window decompressor: config register, core, history and output register.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid / s_tready  s_tuser = op, s_tdata = item_data
//  m_        out  m_tvalid / m_tready  m_tdata = word, count, total; m_tuser = need, status
//  cfg_      in   cfg_valid/cfg_ready  cfg_data = out_length
//
// A mask word, link or literal byte is accepted in ST_IDLE and then decoded in ST_DECODE.
// A copy of L bytes is carried out by the byte-serial history read/write loop.
// Reset is synchronous on aresetn; the history memory is not cleared and needs no sweep.
// A full output register stalls decode and the copy loop until the result is taken.
module lz_window_decompressor #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int LANE_BYTES   = 8,
    parameter int MAX_LENGTH   = 100000000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_data
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [63:0] out_word, [67:64] out_count, [94:68] bytes_total
    output logic [3:0]  m_tuser,   // [1:0] need_next, [3:2] status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [26:0] cfg_data
);

    import lzwd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [CNT_W-1:0] eff_len_reg;
    logic             m_tvalid_reg;
    result_t          res_reg;
    logic             out_free;
    logic             res_valid;
    result_t          res;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic [7:0]       mem_rdata;

    assign cfg_ready = 1'b1;

    // The stored length is saturated at write time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_len_reg <= CNT_W'(1);
        end else if (cfg_valid) begin
            eff_len_reg <= (cfg_data > CNT_W'(MAX_LENGTH)) ? CNT_W'(MAX_LENGTH) : cfg_data;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    lzwd_core #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .LANE_BYTES  (LANE_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_len   (eff_len_reg),
        .item_valid(s_tvalid),
        .item_ready(s_tready),
        .item_op   (s_tuser),
        .item_data (s_tdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    lzwd_history #(
        .DEPTH(WINDOW_DEPTH)
    ) u_history (
        .aclk (aclk),
        .re   (mem_re),
        .raddr(mem_raddr),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg.total, res_reg.count, res_reg.word};
    assign m_tuser  = {res_reg.status, res_reg.need};
    assign m_tlast  = res_reg.last;

endmodule

// File: hdl/lzwd_history.sv
// History window memory: one write port, one registered read port, write-first bypass.
module lzwd_history #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_reg;
    logic       byp_reg;
    logic [7:0] byp_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_reg       <= mem[raddr];
            byp_reg      <= we && (waddr == raddr);
            byp_data_reg <= wdata;
        end
    end

    // A read of the entry being written in the same cycle returns the new byte.
    assign rdata = byp_reg ? byp_data_reg : rd_reg;

endmodule

// File: hdl/lzwd_core.sv
// Item decoder and byte-serial copy sequencer.
module lzwd_core #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int LANE_BYTES   = 8,
    localparam int AW  = $clog2(WINDOW_DEPTH),
    localparam int LCW = $clog2(LANE_BYTES + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [lzwd_pkg::CNT_W-1:0] eff_len,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [1:0]               item_op,
    input  logic [31:0]              item_data,
    input  logic                     out_free,
    output logic                     res_valid,
    output lzwd_pkg::result_t        res,
    output logic                     mem_re,
    output logic [AW-1:0]            mem_raddr,
    output logic                     mem_we,
    output logic [AW-1:0]            mem_waddr,
    output logic [7:0]               mem_wdata,
    input  logic [7:0]               mem_rdata
);

    import lzwd_pkg::*;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
        logic [AW-1:0] nxt;
        nxt = (ptr == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr + AW'(1);
        return nxt;
    endfunction

    state_t                  state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    logic [31:0]             data_reg, data_next;
    logic [CNT_W-1:0]        produced_reg, produced_next;
    logic [31:0]             mask_reg, mask_next;
    logic [5:0]              bits_reg, bits_next;
    logic [15:0]             link_reg, link_next;
    kind_t                   wanted_reg, wanted_next;
    status_t                 err_reg, err_next;
    logic [AW-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0]        issue_reg, issue_next;
    logic [LEN_W-1:0]        deliver_reg, deliver_next;
    logic                    dvld_reg, dvld_next;
    logic [8*LANE_BYTES-1:0] lane_reg, lane_next;
    logic [LCW-1:0]          lane_cnt_reg, lane_cnt_next;
    kind_t                   final_need_reg, final_need_next;

    logic             done_now;
    logic [15:0]      link_word;
    logic [LEN_W-1:0] copy_len;
    logic [12:0]      link_dist;
    logic             too_far;
    logic [CNT_W:0]   sum;
    logic             overrun;
    logic [CNT_W-1:0] lit_prod;
    logic             is_literal;
    logic             is_copy;
    logic [31:0]      mask_sh;
    logic [5:0]       bits_dec;
    kind_t            lit_kind;
    kind_t            copy_kind;
    logic [AW:0]      diff;
    logic [AW-1:0]    rd_start;
    logic             completes;
    logic             adv2;
    logic             iss;
    logic [8*LANE_BYTES-1:0] lane_ins;
    logic [LCW-1:0]   lane_cnt_inc;

    // Decode-time arithmetic on the held item.
    always_comb begin
        done_now   = (produced_reg >= eff_len) || (wanted_reg == KIND_DONE);
        link_word  = (op_reg == KIND_LINK) ? data_reg[15:0] : link_reg;
        copy_len   = (op_reg == KIND_LINK) ? LEN_W'(link_word[15:12]) + SHORT_BIAS
                                           : LEN_W'(data_reg[7:0]) + LONG_BIAS;
        link_dist  = {1'b0, link_word[11:0]} + 13'd1;
        too_far    = CNT_W'(link_dist) > produced_reg;
        sum        = (CNT_W+1)'(produced_reg) + (CNT_W+1)'(copy_len);
        overrun    = sum > (CNT_W+1)'(eff_len);
        lit_prod   = produced_reg + CNT_W'(1);
        is_literal = (op_reg == KIND_BYTE) && mask_reg[31];
        is_copy    = ((op_reg == KIND_LINK) && (data_reg[15:12] != 4'd0))
                     || ((op_reg == KIND_BYTE) && !mask_reg[31]);
        mask_sh    = {mask_reg[30:0], 1'b0};
        bits_dec   = (bits_reg != 6'd0) ? bits_reg - 6'd1 : 6'd0;

        if (lit_prod >= eff_len) begin
            lit_kind = KIND_DONE;
        end else if (bits_dec == 6'd0) begin
            lit_kind = KIND_MASK;
        end else begin
            lit_kind = mask_sh[31] ? KIND_BYTE : KIND_LINK;
        end

        if (sum >= (CNT_W+1)'(eff_len)) begin
            copy_kind = KIND_DONE;
        end else if (bits_dec == 6'd0) begin
            copy_kind = KIND_MASK;
        end else begin
            copy_kind = mask_sh[31] ? KIND_BYTE : KIND_LINK;
        end

        // Source of the copy, taken modulo the window depth.
        diff = {1'b0, wr_ptr_reg} - (AW+1)'(link_dist);
        if (diff[AW]) begin
            rd_start = diff[AW-1:0] + AW'(WINDOW_DEPTH);
        end else begin
            rd_start = diff[AW-1:0];
        end
    end

    // Copy pipeline: issue a read; once the registered read data is valid (dvld_reg), write the byte back and pack it.
    always_comb begin
        completes    = (lane_cnt_reg == LCW'(LANE_BYTES - 1)) || (deliver_reg == LEN_W'(1));
        adv2         = dvld_reg && (!completes || out_free);
        iss          = (state_reg == ST_COPY) && (issue_reg != '0) && (!dvld_reg || adv2);
        lane_cnt_inc = lane_cnt_reg + LCW'(1);
        for (int i = 0; i < LANE_BYTES; i++) begin
            lane_ins[8*i +: 8] = (LCW'(i) == lane_cnt_reg) ? mem_rdata : lane_reg[8*i +: 8];
        end
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign mem_re     = iss;
    assign mem_raddr  = rd_ptr_reg;
    assign mem_waddr  = wr_ptr_reg;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        data_next       = data_reg;
        produced_next   = produced_reg;
        mask_next       = mask_reg;
        bits_next       = bits_reg;
        link_next       = link_reg;
        wanted_next     = wanted_reg;
        err_next        = err_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        issue_next      = issue_reg;
        deliver_next    = deliver_reg;
        dvld_next       = dvld_reg;
        lane_next       = lane_reg;
        lane_cnt_next   = lane_cnt_reg;
        final_need_next = final_need_reg;

        res_valid  = 1'b0;
        res.word   = '0;
        res.count  = '0;
        res.last   = 1'b1;
        res.need   = KIND_DONE;
        res.status = STAT_OK;
        res.total  = produced_reg;
        mem_we     = 1'b0;
        mem_wdata  = mem_rdata;

        case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    op_next    = item_op;
                    data_next  = item_data;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (err_reg != STAT_OK) begin
                        res_valid  = 1'b1;
                        res.status = err_reg;
                    end else if (done_now) begin
                        res_valid   = 1'b1;
                        wanted_next = KIND_DONE;
                    end else if (op_reg != wanted_reg) begin
                        res_valid   = 1'b1;
                        res.status  = STAT_KIND;
                        err_next    = STAT_KIND;
                        wanted_next = KIND_DONE;
                    end else if (op_reg == KIND_MASK) begin
                        mask_next   = data_reg;
                        bits_next   = MASK_BITS;
                        wanted_next = data_reg[31] ? KIND_BYTE : KIND_LINK;
                        res_valid   = 1'b1;
                        res.need    = data_reg[31] ? KIND_BYTE : KIND_LINK;
                    end else if (is_literal) begin
                        mem_we        = 1'b1;
                        mem_wdata     = data_reg[7:0];
                        wr_ptr_next   = wrap_inc(wr_ptr_reg);
                        produced_next = lit_prod;
                        mask_next     = mask_sh;
                        bits_next     = bits_dec;
                        wanted_next   = lit_kind;
                        res_valid     = 1'b1;
                        res.word      = 64'(data_reg[7:0]);
                        res.count     = 4'd1;
                        res.need      = lit_kind;
                        res.total     = lit_prod;
                    end else begin
                        if (op_reg == KIND_LINK) begin
                            link_next = data_reg[15:0];
                        end
                        if (!is_copy) begin
                            // Long link: the length arrives in the next data byte.
                            wanted_next = KIND_BYTE;
                            res_valid   = 1'b1;
                            res.need    = KIND_BYTE;
                        end else if (too_far) begin
                            res_valid   = 1'b1;
                            res.status  = STAT_FAR;
                            err_next    = STAT_FAR;
                            wanted_next = KIND_DONE;
                        end else if (overrun) begin
                            res_valid   = 1'b1;
                            res.status  = STAT_OVERRUN;
                            err_next    = STAT_OVERRUN;
                            wanted_next = KIND_DONE;
                        end else begin
                            mask_next       = mask_sh;
                            bits_next       = bits_dec;
                            wanted_next     = copy_kind;
                            final_need_next = copy_kind;
                            rd_ptr_next     = rd_start;
                            issue_next      = copy_len;
                            deliver_next    = copy_len;
                            dvld_next       = 1'b0;
                            lane_cnt_next   = '0;
                            lane_next       = '0;
                            state_next      = ST_COPY;
                        end
                    end
                end
            end

            ST_COPY: begin
                if (iss) begin
                    rd_ptr_next = wrap_inc(rd_ptr_reg);
                    issue_next  = issue_reg - LEN_W'(1);
                end
                if (!dvld_reg || adv2) begin
                    dvld_next = iss;
                end
                if (adv2) begin
                    mem_we        = 1'b1;
                    mem_wdata     = mem_rdata;
                    wr_ptr_next   = wrap_inc(wr_ptr_reg);
                    produced_next = lit_prod;
                    deliver_next  = deliver_reg - LEN_W'(1);
                    if (completes) begin
                        res_valid     = 1'b1;
                        res.word      = 64'(lane_ins);
                        res.count     = 4'(lane_cnt_inc);
                        res.last      = (deliver_reg == LEN_W'(1));
                        res.need      = final_need_reg;
                        res.total     = lit_prod;
                        lane_next     = '0;
                        lane_cnt_next = '0;
                        if (deliver_reg == LEN_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        lane_next     = lane_ins;
                        lane_cnt_next = lane_cnt_inc;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            produced_reg <= '0;
            mask_reg     <= '0;
            bits_reg     <= '0;
            link_reg     <= '0;
            wanted_reg   <= KIND_MASK;
            err_reg      <= STAT_OK;
            wr_ptr_reg   <= '0;
            issue_reg    <= '0;
            deliver_reg  <= '0;
            dvld_reg     <= 1'b0;
            lane_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            produced_reg <= produced_next;
            mask_reg     <= mask_next;
            bits_reg     <= bits_next;
            link_reg     <= link_next;
            wanted_reg   <= wanted_next;
            err_reg      <= err_next;
            wr_ptr_reg   <= wr_ptr_next;
            issue_reg    <= issue_next;
            deliver_reg  <= deliver_next;
            dvld_reg     <= dvld_next;
            lane_cnt_reg <= lane_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        data_reg       <= data_next;
        rd_ptr_reg     <= rd_ptr_next;
        lane_reg       <= lane_next;
        final_need_reg <= final_need_next;
    end

endmodule
